// ===== src/btmx_pkg.sv =====
package btmx_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_COUNT = 65536;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int ENTRY_W    = 2 * NODE_W;
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NEED_W     = FREE_W + 1;

  localparam logic       FUNC_INSERT = 1'b0;
  localparam logic       FUNC_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

// ===== src/binary_trie_max_xor.sv =====
// Binary trie of keys with a maximum-XOR query and a running maximum.
// Input channel: in_func, in_key, qualified by in_valid; in_stall is raised
// while an item is being processed, so the block takes one item at a time.
// Result channel: out_best_xor, out_running_max and out_status, qualified by
// out_valid. A result waits in the output register while out_stall is high,
// and the block accepts its next item meanwhile; a finished walk holds its
// result until the output register is free.
// Each item walks one trie level per cycle through the node memory, whose
// read data is registered. An insert walks until it finds a missing child
// and then writes one new node per cycle for the remaining levels. A query
// on an empty trie answers with status empty without walking; an insert
// that would exhaust the node pool reports status full and stores nothing.
// The next item can be accepted as soon as a result reaches the output
// register. Reset clears the root, the key flag and the running maximum and
// sets the allocation counter to one; the node memory itself needs no
// clearing pass, since every node is written when it is allocated.
module binary_trie_max_xor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [31:0]                   in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_best_xor,
  output logic [31:0]                   out_running_max,
  output logic [1:0]                    out_status
);
  import btmx_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  entry_t node_mem [NODE_COUNT];
  entry_t rd_data_r;
  node_t  rd_addr_prev_r;

  logic [1:0]          state_r, state_nxt;
  logic                func_r, func_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [LVL_W-1:0]    level_r, level_nxt;
  logic                at_root_r, at_root_nxt;
  logic [KEY_BITS-1:0] xor_r, xor_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;
  logic                holds_r, holds_nxt;
  logic [31:0]         best_r, best_nxt;
  entry_t              root_r, root_nxt;
  logic [31:0]         res_xor_r, res_xor_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_xor_r, out_xor_nxt;
  logic [31:0]         out_max_r, out_max_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  entry_t            cur_entry;
  logic              bit_k;
  node_t             child_same, child_opp;
  logic [NEED_W-1:0] need_total;
  logic              rd_en;
  node_t             rd_addr;
  logic              wr_en;
  node_t             wr_addr;
  entry_t            wr_data;
  logic              in_acc;
  logic              out_free;

  assign cur_entry  = at_root_r ? root_r : rd_data_r;
  assign bit_k      = key_r[level_r];
  assign child_same = cur_entry[(bit_k ? NODE_W : 0) +: NODE_W];
  assign child_opp  = cur_entry[(bit_k ? 0 : NODE_W) +: NODE_W];
  assign need_total = NEED_W'(free_r) + NEED_W'(level_r) + NEED_W'(1);
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    level_nxt      = level_r;
    at_root_nxt    = at_root_r;
    xor_nxt        = xor_r;
    free_nxt       = free_r;
    holds_nxt      = holds_r;
    best_nxt       = best_r;
    root_nxt       = root_r;
    res_xor_nxt    = res_xor_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_xor_nxt    = out_xor_r;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = child_same;
    wr_en          = 1'b0;
    wr_addr        = free_r[NODE_W-1:0];
    wr_data        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_func;
          key_nxt     = in_key[KEY_BITS-1:0];
          level_nxt   = LVL_W'(KEY_BITS - 1);
          at_root_nxt = 1'b1;
          xor_nxt     = '0;
          res_xor_nxt = '0;
          if (in_func == FUNC_QUERY && !holds_r) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (func_r == FUNC_INSERT) begin
          if (child_same == '0) begin
            if (need_total > NEED_W'(NODE_COUNT)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_OUT;
            end else begin
              wr_data = cur_entry;
              wr_data[(bit_k ? NODE_W : 0) +: NODE_W] = free_r[NODE_W-1:0];
              if (at_root_r) begin
                root_nxt = wr_data;
              end else begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_prev_r;
              end
              state_nxt = S_ALLOC;
            end
          end else if (level_r == '0) begin
            holds_nxt      = 1'b1;
            res_status_nxt = ST_OK;
            state_nxt      = S_OUT;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = child_same;
            at_root_nxt = 1'b0;
            level_nxt   = level_r - LVL_W'(1);
          end
        end else begin
          if (child_opp != '0) begin
            xor_nxt[level_r] = 1'b1;
            rd_addr          = child_opp;
          end else begin
            rd_addr = child_same;
          end
          if ((child_opp == '0 && child_same == '0) || level_r == '0) begin
            res_xor_nxt    = 32'(xor_nxt);
            res_status_nxt = ST_OK;
            state_nxt      = S_OUT;
          end else begin
            rd_en       = 1'b1;
            at_root_nxt = 1'b0;
            level_nxt   = level_r - LVL_W'(1);
          end
        end
      end
      S_ALLOC: begin
        wr_en    = 1'b1;
        wr_addr  = free_r[NODE_W-1:0];
        wr_data  = '0;
        free_nxt = free_r + FREE_W'(1);
        if (level_r == '0) begin
          holds_nxt      = 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_OUT;
        end else begin
          wr_data[(key_r[level_r - LVL_W'(1)] ? NODE_W : 0) +: NODE_W] =
            free_nxt[NODE_W-1:0];
          level_nxt = level_r - LVL_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          if (func_r == FUNC_QUERY && res_status_r == ST_OK && res_xor_r > best_r) begin
            best_nxt = res_xor_r;
          end
          out_valid_nxt  = 1'b1;
          out_xor_nxt    = res_xor_r;
          out_max_nxt    = best_nxt;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r      <= node_mem[rd_addr];
      rd_addr_prev_r <= rd_addr;
    end
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= FREE_W'(1);
      holds_r     <= 1'b0;
      best_r      <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      holds_r     <= holds_nxt;
      best_r      <= best_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    level_r      <= level_nxt;
    at_root_r    <= at_root_nxt;
    xor_r        <= xor_nxt;
    res_xor_r    <= res_xor_nxt;
    res_status_r <= res_status_nxt;
    out_xor_r    <= out_xor_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_best_xor    = out_xor_r;
  assign out_running_max = out_max_r;
  assign out_status      = out_status_r;

  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r != '0 && free_r <= FREE_W'(NODE_COUNT))
    else $error("allocation counter left the node pool");

  a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> free_r < FREE_W'(NODE_COUNT))
    else $error("node written beyond the pool");

  a_holds_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    holds_r |=> holds_r)
    else $error("key flag cleared outside reset");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    best_nxt >= best_r)
    else $error("running maximum decreased");

  a_nonok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_xor_r == '0)
    else $error("failed transaction carries a nonzero result");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btmx_pkg::*;

  typedef struct packed {
    logic [31:0] best_xor;
    logic [31:0] running_max;
    logic [1:0]  status;
  } xor_result_t;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic        typed;
    xor_result_t want;
  } plan_row_t;

  localparam int PLAN_ROWS   = 23;
  localparam int QUIET_LIMIT = 5000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_func   = FUNC_INSERT;
  logic [31:0] in_key    = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_best_xor;
  logic [31:0] out_running_max;
  logic [1:0]  out_status;

  binary_trie_max_xor DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_xor    (out_best_xor),
    .out_running_max (out_running_max),
    .out_status      (out_status)
  );

  // Shadow trie: two child indexes per node, zero meaning no child.
  node_t       trie_kids [NODE_COUNT][2];
  int unsigned next_node   = 1;
  bit          trie_loaded = 1'b0;
  logic [31:0] xor_peak    = '0;

  logic [31:0] stored_keys [$];
  xor_result_t awaited_results [$];
  int          mismatches     = 0;
  int          accepted_items = 0;
  int          full_reports   = 0;
  int          burst_left     = 0;
  int          quiet_cycles   = 0;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    {FUNC_QUERY,  32'h00000000, 1'b1, 32'h00000000, 32'h00000000, ST_EMPTY},
    {FUNC_QUERY,  32'hFFFFFFFF, 1'b1, 32'h00000000, 32'h00000000, ST_EMPTY},
    {FUNC_INSERT, 32'h00000000, 1'b1, 32'h00000000, 32'h00000000, ST_OK},
    {FUNC_INSERT, 32'h00000000, 1'b1, 32'h00000000, 32'h00000000, ST_OK},
    {FUNC_QUERY,  32'h00000000, 1'b1, 32'h00000000, 32'h00000000, ST_OK},
    {FUNC_QUERY,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, ST_OK},
    {FUNC_INSERT, 32'hFFFFFFFF, 1'b1, 32'h00000000, 32'hFFFFFFFF, ST_OK},
    {FUNC_QUERY,  32'h80000000, 1'b1, 32'h80000000, 32'hFFFFFFFF, ST_OK},
    {FUNC_QUERY,  32'h00000000, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, ST_OK},
    {FUNC_INSERT, 32'h55555555, 1'b0, 66'h0},
    {FUNC_INSERT, 32'hAAAAAAAA, 1'b0, 66'h0},
    {FUNC_QUERY,  32'h55555555, 1'b0, 66'h0},
    {FUNC_QUERY,  32'hAAAAAAAA, 1'b0, 66'h0},
    {FUNC_INSERT, 32'h00000001, 1'b0, 66'h0},
    {FUNC_INSERT, 32'h80000000, 1'b0, 66'h0},
    {FUNC_QUERY,  32'h7FFFFFFF, 1'b0, 66'h0},
    {FUNC_QUERY,  32'h00000001, 1'b0, 66'h0},
    {FUNC_INSERT, 32'h12345678, 1'b0, 66'h0},
    {FUNC_INSERT, 32'h12345679, 1'b0, 66'h0},
    {FUNC_QUERY,  32'hEDCBA987, 1'b0, 66'h0},
    {FUNC_INSERT, 32'h7FFFFFFF, 1'b0, 66'h0},
    {FUNC_QUERY,  32'h00010000, 1'b0, 66'h0},
    {FUNC_QUERY,  32'hFFFF0000, 1'b0, 66'h0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic xor_result_t trie_apply(input logic func, input logic [31:0] key);
    xor_result_t res;
    int          node;
    int          lvl;
    int          need;
    node_t       kid;
    logic        bit_now;
    bit          stop;
    res  = '0;
    node = 0;
    need = 0;
    stop = 1'b0;
    if (func == FUNC_INSERT) begin
      for (lvl = KEY_BITS - 1; lvl >= 0 && !stop; lvl--) begin
        kid = trie_kids[node][key[lvl]];
        if (kid == 0) begin
          need = lvl + 1;
          stop = 1'b1;
        end else begin
          node = int'(kid);
        end
      end
      if (next_node + need > NODE_COUNT) begin
        res.status = ST_FULL;
      end else begin
        node = 0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          bit_now = key[lvl];
          kid = trie_kids[node][bit_now];
          if (kid == 0) begin
            kid = node_t'(next_node);
            next_node++;
            trie_kids[kid][0] = '0;
            trie_kids[kid][1] = '0;
            trie_kids[node][bit_now] = kid;
          end
          node = int'(kid);
        end
        trie_loaded = 1'b1;
        res.status = ST_OK;
      end
    end else if (!trie_loaded) begin
      res.status = ST_EMPTY;
    end else begin
      for (lvl = KEY_BITS - 1; lvl >= 0 && !stop; lvl--) begin
        bit_now = key[lvl];
        kid = trie_kids[node][!bit_now];
        if (kid != 0) begin
          res.best_xor[lvl] = 1'b1;
          node = int'(kid);
        end else begin
          kid = trie_kids[node][bit_now];
          if (kid == 0) begin
            stop = 1'b1;
          end else begin
            node = int'(kid);
          end
        end
      end
      if (res.best_xor > xor_peak) begin
        xor_peak = res.best_xor;
      end
      res.status = ST_OK;
    end
    res.running_max = xor_peak;
    return res;
  endfunction

  task automatic send_item(input logic func, input logic [31:0] key, input logic typed,
                           input xor_result_t want);
    xor_result_t predicted;
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_items++;
    predicted = trie_apply(func, key);
    if (func == FUNC_INSERT && predicted.status == ST_OK) begin
      stored_keys.insert(stored_keys.size(), key);
    end
    if (predicted.status == ST_FULL) begin
      full_reports++;
    end
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
  endtask

  task automatic sender_gap(input bit drain);
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      span = 0;
    end else if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      span = 0;
    end else if (r < 55) begin
      span = 0;
    end else if (r < 92) begin
      span = $urandom_range(1, 3);
    end else if (r < 99) begin
      span = $urandom_range(4, 20);
    end else begin
      span = $urandom_range(40, 120);
    end
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (awaited_results.size() != 0) @(posedge clk);
    end else if (span != 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // The receiver paces itself; one long hold lets the block fill up and push back.
  initial begin : sink_pacing
    int r;
    int span;
    int calm_left;
    bit hold_done;
    logic stall_now;
    calm_left = 0;
    hold_done = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && accepted_items >= 40) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        span = 400;
      end else if (calm_left > 0) begin
        calm_left--;
        stall_now = 1'b0;
        span = 1;
      end else if (r < 3) begin
        calm_left = $urandom_range(20, 80);
        stall_now = 1'b0;
        span = 1;
      end else if (r < 60) begin
        stall_now = 1'b0;
        span = $urandom_range(1, 4);
      end else if (r < 95) begin
        stall_now = 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        stall_now = 1'b1;
        span = $urandom_range(10, 150);
      end
      out_stall <= stall_now;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    xor_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected: %s%h %s%h %s%0d",
                 $time, "best_xor=", out_best_xor, "running_max=", out_running_max,
                 "status=", out_status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_best_xor !== want.best_xor) begin
          $display("%0t: best_xor expected %h actual %h", $time, want.best_xor, out_best_xor);
          mismatches++;
        end
        if (out_running_max !== want.running_max) begin
          $display("%0t: running_max expected %h actual %h",
                   $time, want.running_max, out_running_max);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL binary_trie_max_xor");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    logic        func;
    logic [31:0] key;
    logic [31:0] flip;
    logic [11:0] lane;
    int          r;
    int          b;
    int          rand_items;
    int          spread_idx;
    int          t_spread, t_dup, t_near, t_ins, t_stored, t_compl, t_rand;
    bit          drained_on_full;
    bit          drain;
    rand_items      = 0;
    spread_idx      = 0;
    drained_on_full = 1'b0;
    trie_kids[0][0] = '0;
    trie_kids[0][1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = directed_plan[i];
      send_item(row.func, row.key, row.typed, row.want);
      sender_gap(i == PLAN_ROWS - 1);
    end

    // Keys with bit-reversed prefixes spread across the trie, among other random items.
    while (rand_items < 1450 - PLAN_ROWS) begin
      if (full_reports == 0) begin
        t_spread = 85; t_dup = 87; t_near = 89; t_ins = 91;
        t_stored = 94; t_compl = 96; t_rand = 98;
      end else begin
        t_spread = 25; t_dup = 35; t_near = 50; t_ins = 55;
        t_stored = 70; t_compl = 80; t_rand = 92;
      end
      r    = $urandom_range(0, 99);
      key  = $urandom;
      flip = 32'h1 << $urandom_range(0, 31);
      func = FUNC_QUERY;
      if (r < t_spread) begin
        func = FUNC_INSERT;
        for (b = 0; b < 12; b++) lane[b] = spread_idx[11 - b];
        key = {lane, key[19:0]};
        spread_idx++;
      end else if (r < t_dup) begin
        func = FUNC_INSERT;
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (r < t_near) begin
        func = FUNC_INSERT;
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)] ^
              (32'h1 << $urandom_range(0, 3));
      end else if (r < t_ins) begin
        func = FUNC_INSERT;
      end else if (r < t_stored) begin
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (r < t_compl) begin
        key = ~stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (r >= t_rand) begin
        case ($urandom_range(0, 3))
          0: key = 32'h00000000;
          1: key = 32'hFFFFFFFF;
          2: key = flip;
          default: key = ~flip;
        endcase
      end
      send_item(func, key, 1'b0, '0);
      rand_items++;
      drain = ($urandom_range(0, 299) == 0);
      if (full_reports > 0 && !drained_on_full) begin
        drained_on_full = 1'b1;
        drain = 1'b1;
      end
      sender_gap(drain);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS binary_trie_max_xor");
    end else begin
      $display("FAIL binary_trie_max_xor");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/btmx_pkg.sv
src/binary_trie_max_xor.sv
bench/tb_top.sv
